### rtl/fem1_pkg.sv
package fem1_pkg;

   // Transaction payloads
   typedef struct packed {
      logic [31:0] x_bits;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [31:0] y_bits;
      logic        last_out;
   } rsp_type;

   // Pipeline depths of the float units and of the whole datapath
   localparam int MUL_LAT   = 3;
   localparam int ADD_LAT   = 4;
   localparam int TOTAL_LAT = 5 * MUL_LAT + 7 * ADD_LAT;

   // Single-precision constants
   localparam logic [31:0] MAGIC_BIAS = 32'h4940_0000;
   localparam logic [31:0] NEG_MAGIC  = 32'hC940_0000;
   localparam logic [31:0] LOG2E      = 32'h3FB8_AA3B;
   localparam logic [31:0] MLN2_HI    = 32'hBF31_7200;
   localparam logic [31:0] MLN2_LO    = 32'hB5BF_BE8E;
   localparam logic [31:0] C3         = 32'h3E2A_AB0E;
   localparam logic [31:0] C2         = 32'h3F00_00F6;
   localparam logic [31:0] NEG_ONE    = 32'hBF80_0000;
   localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
   localparam logic [30:0] CUTOFF_MAG = 31'h418A_A123;
   localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
   localparam int          EXP_SHIFT  = 19;

   // exp2(k/16) as single precision, less k << 19
   function automatic logic [31:0] exp2_tbl(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd0:    v = 32'h3F80_0000;
         4'd1:    v = 32'h3F7D_AAC3;
         4'd2:    v = 32'h3F7B_95C2;
         4'd3:    v = 32'h3F79_C3D3;
         4'd4:    v = 32'h3F78_37F0;
         4'd5:    v = 32'h3F76_F532;
         4'd6:    v = 32'h3F75_FED7;
         4'd7:    v = 32'h3F75_583F;
         4'd8:    v = 32'h3F75_04F3;
         4'd9:    v = 32'h3F75_08A4;
         4'd10:   v = 32'h3F75_672A;
         4'd11:   v = 32'h3F76_248C;
         4'd12:   v = 32'h3F77_44FD;
         4'd13:   v = 32'h3F78_CCDF;
         4'd14:   v = 32'h3F7A_C0C7;
         default: v = 32'h3F7D_257D;
      endcase
      return v;
   endfunction

   // Leading zero count of a 24-bit mantissa
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       done;
      n    = 5'd0;
      done = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!done) begin
            if (v[i]) done = 1'b1;
            else      n = n + 5'd1;
         end
      end
      return n;
   endfunction

   // Leading zero count of a 27-bit sum
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       done;
      n    = 5'd0;
      done = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!done) begin
            if (v[i]) done = 1'b1;
            else      n = n + 5'd1;
         end
      end
      return n;
   endfunction

endpackage

### rtl/fem1_fmul.sv
module fem1_fmul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // Stage 1: unpack, classify, normalize subnormal mantissas
   logic              a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
   logic              sign_in, spec_in;
   logic [31:0]       specval_in;
   logic [4:0]        lz_a, lz_b;
   logic [23:0]       ma_in, mb_in;
   logic signed [9:0] ea_in, eb_in;

   always_comb begin
      a_zero  = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
      b_zero  = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
      a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      sign_in = a[31] ^ b[31];
      spec_in = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
         specval_in = fem1_pkg::CANON_NAN;
      else if (a_inf || b_inf)
         specval_in = {sign_in, 8'hFF, 23'd0};
      else
         specval_in = {sign_in, 31'd0};
      lz_a = fem1_pkg::lzc24({1'b0, a[22:0]});
      lz_b = fem1_pkg::lzc24({1'b0, b[22:0]});
      if (a[30:23] != 8'd0) begin
         ma_in = {1'b1, a[22:0]};
         ea_in = signed'({2'b00, a[30:23]});
      end else begin
         ma_in = {1'b0, a[22:0]} << lz_a;
         ea_in = 10'sd1 - signed'({5'd0, lz_a});
      end
      if (b[30:23] != 8'd0) begin
         mb_in = {1'b1, b[22:0]};
         eb_in = signed'({2'b00, b[30:23]});
      end else begin
         mb_in = {1'b0, b[22:0]} << lz_b;
         eb_in = 10'sd1 - signed'({5'd0, lz_b});
      end
   end

   logic              s1_sign_ff, s1_spec_ff;
   logic [31:0]       s1_specval_ff;
   logic [23:0]       s1_ma_ff, s1_mb_ff;
   logic signed [9:0] s1_ea_ff, s1_eb_ff;

   always_ff @(posedge clock) begin
      s1_sign_ff    <= sign_in;
      s1_spec_ff    <= spec_in;
      s1_specval_ff <= specval_in;
      s1_ma_ff      <= ma_in;
      s1_mb_ff      <= mb_in;
      s1_ea_ff      <= ea_in;
      s1_eb_ff      <= eb_in;
   end

   // Stage 2: mantissa product and exponent sum
   logic [47:0]        s2_prod_ff;
   logic signed [10:0] s2_exp_ff;
   logic               s2_sign_ff, s2_spec_ff;
   logic [31:0]        s2_specval_ff;

   always_ff @(posedge clock) begin
      s2_prod_ff    <= s1_ma_ff * s1_mb_ff;
      s2_exp_ff     <= 11'(s1_ea_ff) + 11'(s1_eb_ff) - 11'sd127;
      s2_sign_ff    <= s1_sign_ff;
      s2_spec_ff    <= s1_spec_ff;
      s2_specval_ff <= s1_specval_ff;
   end

   // Stage 3: normalize, denormalize on underflow, round to nearest even
   logic [47:0]        m, ms, mask;
   logic signed [10:0] e_norm, sh_full;
   logic [7:0]         sh;
   logic [23:0]        keep;
   logic               g, st, inc;
   logic [30:0]        base;
   logic [31:0]        res;

   always_comb begin
      m       = s2_prod_ff[47] ? s2_prod_ff : {s2_prod_ff[46:0], 1'b0};
      e_norm  = s2_exp_ff + 11'(s2_prod_ff[47]);
      sh_full = 11'sd1 - e_norm;
      sh      = sh_full[7:0];
      mask    = ~({48{1'b1}} << sh);
      ms      = m >> sh;
      if (e_norm >= 11'sd1) begin
         keep = m[47:24];
         g    = m[23];
         st   = |m[22:0];
         base = {e_norm[7:0] - 8'd1, 23'd0} + {7'd0, keep};
      end else begin
         keep = ms[47:24];
         g    = ms[23];
         st   = (|ms[22:0]) | (|(m & mask));
         base = {7'd0, keep};
      end
      inc = g & (st | base[0]);
      if (e_norm >= 11'sd255)
         res = {s2_sign_ff, 8'hFF, 23'd0};
      else
         res = {s2_sign_ff, base + 31'(inc)};
   end

   logic [31:0] y_ff;

   always_ff @(posedge clock) begin
      y_ff <= s2_spec_ff ? s2_specval_ff : res;
   end

   assign y = y_ff;

endmodule

### rtl/fem1_fadd.sv
module fem1_fadd (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // Stage 1: classify, order by magnitude, align the smaller operand
   logic        a_inf, a_nan, b_inf, b_nan, swap, spec_in;
   logic [31:0] specval_in, big, sml;
   logic [7:0]  be, se, diff;
   logic [26:0] big_in, sml27, sml_sh, sml_mask, sml_in;

   always_comb begin
      a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      spec_in = a_nan | b_nan | a_inf | b_inf;
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
         specval_in = fem1_pkg::CANON_NAN;
      else if (a_inf)
         specval_in = {a[31], 8'hFF, 23'd0};
      else
         specval_in = {b[31], 8'hFF, 23'd0};
      swap     = b[30:0] > a[30:0];
      big      = swap ? b : a;
      sml      = swap ? a : b;
      be       = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      se       = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      diff     = be - se;
      big_in   = {big[30:23] != 8'd0, big[22:0], 3'b000};
      sml27    = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      sml_sh   = sml27 >> diff;
      sml_mask = ~({27{1'b1}} << diff);
      sml_in   = {sml_sh[26:1], sml_sh[0] | (|(sml27 & sml_mask))};
   end

   logic        s1_sign_ff, s1_sub_ff, s1_zsign_ff, s1_spec_ff;
   logic [31:0] s1_specval_ff;
   logic [7:0]  s1_exp_ff;
   logic [26:0] s1_big_ff, s1_sml_ff;

   always_ff @(posedge clock) begin
      s1_sign_ff    <= big[31];
      s1_sub_ff     <= big[31] ^ sml[31];
      s1_zsign_ff   <= a[31] & b[31];
      s1_spec_ff    <= spec_in;
      s1_specval_ff <= specval_in;
      s1_exp_ff     <= be;
      s1_big_ff     <= big_in;
      s1_sml_ff     <= sml_in;
   end

   // Stage 2: add or subtract the aligned mantissas
   logic [27:0] s2_sum_ff;
   logic [7:0]  s2_exp_ff;
   logic        s2_sign_ff, s2_zsign_ff, s2_spec_ff;
   logic [31:0] s2_specval_ff;

   always_ff @(posedge clock) begin
      if (s1_sub_ff)
         s2_sum_ff <= {1'b0, s1_big_ff} - {1'b0, s1_sml_ff};
      else
         s2_sum_ff <= {1'b0, s1_big_ff} + {1'b0, s1_sml_ff};
      s2_exp_ff     <= s1_exp_ff;
      s2_sign_ff    <= s1_sign_ff;
      s2_zsign_ff   <= s1_zsign_ff;
      s2_spec_ff    <= s1_spec_ff;
      s2_specval_ff <= s1_specval_ff;
   end

   // Stage 3: normalize, stopping at the smallest exponent
   logic [4:0]  lz, nsh;
   logic [7:0]  max_sh;
   logic [26:0] norm_in;
   logic [8:0]  e_in;

   always_comb begin
      lz     = fem1_pkg::lzc27(s2_sum_ff[26:0]);
      max_sh = s2_exp_ff - 8'd1;
      nsh    = ({3'd0, lz} < max_sh) ? lz : max_sh[4:0];
      if (s2_sum_ff[27]) begin
         norm_in = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         e_in    = {1'b0, s2_exp_ff} + 9'd1;
      end else begin
         norm_in = s2_sum_ff[26:0] << nsh;
         e_in    = {1'b0, s2_exp_ff} - {4'd0, nsh};
      end
   end

   logic [26:0] s3_norm_ff;
   logic [8:0]  s3_exp_ff;
   logic        s3_sign_ff, s3_zero_ff, s3_zsign_ff, s3_spec_ff;
   logic [31:0] s3_specval_ff;

   always_ff @(posedge clock) begin
      s3_norm_ff    <= norm_in;
      s3_exp_ff     <= e_in;
      s3_sign_ff    <= s2_sign_ff;
      s3_zero_ff    <= (s2_sum_ff == 28'd0);
      s3_zsign_ff   <= s2_zsign_ff;
      s3_spec_ff    <= s2_spec_ff;
      s3_specval_ff <= s2_specval_ff;
   end

   // Stage 4: round to nearest even and pack
   logic [30:0] base;
   logic        inc;
   logic [31:0] res;

   always_comb begin
      base = {s3_exp_ff[7:0] - 8'd1, 23'd0} + {7'd0, s3_norm_ff[26:3]};
      inc  = s3_norm_ff[2] & ((|s3_norm_ff[1:0]) | base[0]);
      if (s3_spec_ff)
         res = s3_specval_ff;
      else if (s3_zero_ff)
         res = {s3_zsign_ff, 31'd0};
      else if (s3_exp_ff == 9'd255)
         res = {s3_sign_ff, 8'hFF, 23'd0};
      else
         res = {s3_sign_ff, base + 31'(inc)};
   end

   logic [31:0] y_ff;

   always_ff @(posedge clock) begin
      y_ff <= res;
   end

   assign y = y_ff;

endmodule

### rtl/float_expm1_negative_top.sv
// exp(x)-1 in single precision for x meant in [-17.33, 0]. One transaction
// is taken in every clock cycle (busy is always low) and its result appears
// on rsp_data, marked by rsp_strobe for one cycle, once it has passed the
// chain of twelve dependent multiply and add units (3 and 4 stages each)
// and the output register. Results come back in order and cannot be held
// off, so the receiver must take every strobe. x at or below about -17.33,
// and -inf, give exactly -1.0; any NaN result comes back as 0x7FC00000.
module float_expm1_negative_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fem1_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fem1_pkg::rsp_type rsp_data
);

   localparam int X_DLY   = 14;
   localparam int CUT_DLY = 22;
   localparam int S_DLY   = 15;
   localparam int B_DLY   = 4;
   localparam int T_DLY   = 7;
   localparam int TS_DLY  = 10;
   localparam int SM1_DLY = 13;

   logic [31:0] x, m1, n_bits, nm, s_raw, a_p, b_p, t1, t_raw, tz, sz;
   logic [31:0] c_p, ts, sm1, p1, p_p, q_p, r_s, y_s, y_fix;
   logic        cut;

   assign busy = 1'b0;
   assign x    = req_data.x_bits;
   assign cut  = x[31] && (x[30:0] >= fem1_pkg::CUTOFF_MAG) &&
                 (x[30:0] <= fem1_pkg::INF_MAG);

   // Delay lines that line operands up with the unit latencies
   logic [31:0] x_dly_ff   [X_DLY];
   logic        cut_dly_ff [CUT_DLY];
   logic [31:0] s_dly_ff   [S_DLY];
   logic [31:0] b_dly_ff   [B_DLY];
   logic [31:0] t_dly_ff   [T_DLY];
   logic [31:0] ts_dly_ff  [TS_DLY];
   logic [31:0] sm1_dly_ff [SM1_DLY];

   always_ff @(posedge clock) begin
      x_dly_ff[0]   <= x;
      cut_dly_ff[0] <= cut;
      s_dly_ff[0]   <= s_raw;
      b_dly_ff[0]   <= b_p;
      t_dly_ff[0]   <= tz;
      ts_dly_ff[0]  <= ts;
      sm1_dly_ff[0] <= sm1;
      for (int i = 1; i < X_DLY; i++)   x_dly_ff[i]   <= x_dly_ff[i-1];
      for (int i = 1; i < CUT_DLY; i++) cut_dly_ff[i] <= cut_dly_ff[i-1];
      for (int i = 1; i < S_DLY; i++)   s_dly_ff[i]   <= s_dly_ff[i-1];
      for (int i = 1; i < B_DLY; i++)   b_dly_ff[i]   <= b_dly_ff[i-1];
      for (int i = 1; i < T_DLY; i++)   t_dly_ff[i]   <= t_dly_ff[i-1];
      for (int i = 1; i < TS_DLY; i++)  ts_dly_ff[i]  <= ts_dly_ff[i-1];
      for (int i = 1; i < SM1_DLY; i++) sm1_dly_ff[i] <= sm1_dly_ff[i-1];
   end

   // Round x*log2e to 4 fractional bits, then remove the bias
   fem1_fmul u_m1 (.clock(clock), .a(x), .b(fem1_pkg::LOG2E), .y(m1));
   fem1_fadd u_n  (.clock(clock), .a(m1), .b(fem1_pkg::MAGIC_BIAS), .y(n_bits));
   fem1_fadd u_nm (.clock(clock), .a(n_bits), .b(fem1_pkg::NEG_MAGIC), .y(nm));

   // Build the scale from the table and the shifted rounding bits
   assign s_raw = fem1_pkg::exp2_tbl(n_bits[3:0]) +
                  {n_bits[31-fem1_pkg::EXP_SHIFT:0], {fem1_pkg::EXP_SHIFT{1'b0}}};

   // Two-constant reduction
   fem1_fmul u_a  (.clock(clock), .a(nm), .b(fem1_pkg::MLN2_HI), .y(a_p));
   fem1_fmul u_b  (.clock(clock), .a(nm), .b(fem1_pkg::MLN2_LO), .y(b_p));
   fem1_fadd u_t1 (.clock(clock), .a(a_p), .b(x_dly_ff[X_DLY-1]), .y(t1));
   fem1_fadd u_t  (.clock(clock), .a(b_dly_ff[B_DLY-1]), .b(t1), .y(t_raw));

   // Saturate: zero scale and reduced argument
   assign tz = cut_dly_ff[CUT_DLY-1] ? 32'd0 : t_raw;
   assign sz = cut_dly_ff[CUT_DLY-1] ? 32'd0 : s_dly_ff[S_DLY-1];

   // Polynomial and reconstruction
   fem1_fmul u_c   (.clock(clock), .a(fem1_pkg::C3), .b(tz), .y(c_p));
   fem1_fmul u_ts  (.clock(clock), .a(tz), .b(sz), .y(ts));
   fem1_fadd u_sm1 (.clock(clock), .a(sz), .b(fem1_pkg::NEG_ONE), .y(sm1));
   fem1_fadd u_p1  (.clock(clock), .a(c_p), .b(fem1_pkg::C2), .y(p1));
   fem1_fmul u_p   (.clock(clock), .a(p1), .b(t_dly_ff[T_DLY-1]), .y(p_p));
   fem1_fmul u_q   (.clock(clock), .a(p_p), .b(ts_dly_ff[T_DLY-1]), .y(q_p));
   fem1_fadd u_r   (.clock(clock), .a(q_p), .b(ts_dly_ff[TS_DLY-1]), .y(r_s));
   fem1_fadd u_y   (.clock(clock), .a(r_s), .b(sm1_dly_ff[SM1_DLY-1]), .y(y_s));

   // Canonicalize NaN results
   assign y_fix = ((y_s[30:23] == 8'hFF) && (y_s[22:0] != 23'd0)) ?
                  fem1_pkg::CANON_NAN : y_s;

   // Advance valid and last flags alongside the datapath
   logic vld_ff  [fem1_pkg::TOTAL_LAT];
   logic last_ff [fem1_pkg::TOTAL_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fem1_pkg::TOTAL_LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int i = 1; i < fem1_pkg::TOTAL_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      last_ff[0] <= req_data.last_in;
      for (int i = 1; i < fem1_pkg::TOTAL_LAT; i++) last_ff[i] <= last_ff[i-1];
   end

   // Hold the result for one strobe cycle
   logic              rsp_strobe_ff;
   fem1_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[fem1_pkg::TOTAL_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.y_bits   <= y_fix;
      rsp_data_ff.last_out <= last_ff[fem1_pkg::TOTAL_LAT-1];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### tb/tb_float_expm1_negative_top.sv
`timescale 1ns / 1ps

// Bit-exact predictor of exp(x)-1 and the in-order store of pending results
class expm1_scoreboard;
   fem1_pkg::rsp_type pending[$];
   int                errors;

   function new();
      errors = 0;
   endfunction

   // exp2(k/16) patterns, each less k << 19
   static function logic [31:0] scale_entry(input logic [3:0] k);
      logic [31:0] rom [16];
      rom = '{32'h3F800000, 32'h3F7DAAC3, 32'h3F7B95C2, 32'h3F79C3D3,
              32'h3F7837F0, 32'h3F76F532, 32'h3F75FED7, 32'h3F75583F,
              32'h3F7504F3, 32'h3F7508A4, 32'h3F75672A, 32'h3F76248C,
              32'h3F7744FD, 32'h3F78CCDF, 32'h3F7AC0C7, 32'h3F7D257D};
      return rom[k];
   endfunction

   static function bit is_nan(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
   endfunction

   static function bit is_inf(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 0;
   endfunction

   static function bit is_zero(input logic [31:0] a);
      return a[30:0] == 0;
   endfunction

   // Split into integer mantissa and exponent of its lsb
   static function void split(input logic [31:0] a, output logic [63:0] m, output int e);
      if (a[30:23] == 0) begin
         m = {41'b0, a[22:0]};
         e = -149;
      end else begin
         m = {40'b0, 1'b1, a[22:0]};
         e = int'(a[30:23]) - 150;
      end
   endfunction

   // Round m * 2^e (bit 0 may carry sticky) to single precision, nearest-even
   static function logic [31:0] round_pack(input bit s, input logic [63:0] m, input int e);
      int          p;
      int          lsb;
      int          sh;
      logic [63:0] q;
      logic [24:0] mant;
      bit          g;
      bit          st;
      if (m == 0) return {s, 31'b0};
      p = 63;
      while (!m[p]) p--;
      if (p + e > 127) return {s, 8'hFF, 23'b0};
      lsb = (p + e < -126) ? -126 : p + e;
      lsb = lsb - 23;
      sh = lsb - e;
      g = 0;
      st = 0;
      if (sh <= 0) begin
         mant = 25'(m << (-sh));
      end else if (sh > 64) begin
         mant = 0;
         st = 1;
      end else begin
         q = m >> (sh - 1);
         g = q[0];
         mant = 25'(q >> 1);
         st = |(m & ((64'd1 << (sh - 1)) - 64'd1));
      end
      if (g && (st || mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
         mant = mant >> 1;
         lsb++;
      end
      if (mant[23]) begin
         if (lsb + 150 >= 255) return {s, 8'hFF, 23'b0};
         return {s, 8'(lsb + 150), mant[22:0]};
      end
      return {s, 8'h00, mant[22:0]};
   endfunction

   static function logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      int          ea;
      int          eb;
      bit          s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return fem1_pkg::CANON_NAN;
      if (is_inf(a) || is_inf(b)) begin
         if (is_zero(a) || is_zero(b)) return fem1_pkg::CANON_NAN;
         return {s, 8'hFF, 23'b0};
      end
      if (is_zero(a) || is_zero(b)) return {s, 31'b0};
      split(a, ma, ea);
      split(b, mb, eb);
      return round_pack(s, ma * mb, ea + eb);
   endfunction

   static function logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] tmp;
      int          ea;
      int          eb;
      int          d;
      int          e;
      if (is_nan(a) || is_nan(b)) return fem1_pkg::CANON_NAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fem1_pkg::CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'b0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      split(a, ma, ea);
      split(b, mb, eb);
      // keep the operand with the larger exponent in a
      if (eb > ea) begin
         tmp = a; a = b; b = tmp;
         split(a, ma, ea);
         split(b, mb, eb);
      end
      d = ea - eb;
      if (d > 40) begin
         hi = ma << 40;
         e = ea - 40;
         if (d - 40 >= 24) lo = (mb != 0) ? 64'd1 : 64'd0;
         else begin
            lo = mb >> (d - 40);
            if ((lo << (d - 40)) != mb) lo = lo | 64'd1;
         end
      end else begin
         hi = ma << d;
         lo = mb;
         e = eb;
      end
      if (a[31] == b[31]) return round_pack(a[31], hi + lo, e);
      if (hi == lo) return 32'h0;
      if (hi > lo) return round_pack(a[31], hi - lo, e);
      return round_pack(b[31], lo - hi, e);
   endfunction

   static function logic [31:0] expm1_bits(input logic [31:0] x);
      logic [31:0] n;
      logic [31:0] scale;
      logic [31:0] t;
      logic [31:0] p;
      logic [31:0] ts;
      logic [31:0] sm1;
      logic [31:0] y;
      n = fadd(fmul(x, fem1_pkg::LOG2E), fem1_pkg::MAGIC_BIAS);
      scale = scale_entry(n[3:0]) + (n << fem1_pkg::EXP_SHIFT);
      n = fadd(n, fem1_pkg::NEG_MAGIC);
      t = fadd(fmul(n, fem1_pkg::MLN2_HI), x);
      t = fadd(fmul(n, fem1_pkg::MLN2_LO), t);
      // saturate at or below the cutoff, -inf included
      if (x[31] && x[30:0] >= fem1_pkg::CUTOFF_MAG && !is_nan(x)) begin
         scale = 32'h0;
         t = 32'h0;
      end
      p = fadd(fmul(fem1_pkg::C3, t), fem1_pkg::C2);
      p = fmul(p, t);
      ts = fmul(t, scale);
      sm1 = fadd(scale, fem1_pkg::NEG_ONE);
      p = fadd(fmul(p, ts), ts);
      y = fadd(p, sm1);
      if (is_nan(y)) y = fem1_pkg::CANON_NAN;
      return y;
   endfunction

   function void note(input fem1_pkg::req_type req);
      fem1_pkg::rsp_type r;
      r.y_bits = expm1_bits(req.x_bits);
      r.last_out = req.last_in;
      pending.push_back(r);
   endfunction

   function void check(input fem1_pkg::rsp_type got);
      fem1_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $error("result with nothing pending: y_bits %h", got.y_bits);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.y_bits !== want.y_bits) begin
         $error("y_bits expected %h actual %h", want.y_bits, got.y_bits);
         errors++;
      end
      if (got.last_out !== want.last_out) begin
         $error("last_out expected %b actual %b", want.last_out, got.last_out);
         errors++;
      end
   endfunction
endclass

module tb_float_expm1_negative_top;

   localparam int CYCLE_LIMIT = 200000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   fem1_pkg::req_type req_data;
   logic              rsp_strobe;
   fem1_pkg::rsp_type rsp_data;

   expm1_scoreboard board;
   int              idle_pct;
   int              cycles;

   float_expm1_negative_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check(rsp_data);
   end

   // Drive one transaction, holding it until the block takes it
   task automatic send(input logic [31:0] x, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data.x_bits = x;
      req_data.last_in = last;
      do @(posedge clock); while (busy);
      board.note(req_data);
      @(negedge clock);
   endtask

   // Mostly x in the working range, some anywhere
   function automatic logic [31:0] random_x();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return {1'b1, 8'($urandom_range(131, 100)), 23'($urandom)};
      if (pick < 80) return {1'b1, 8'($urandom_range(131, 0)), 23'($urandom)};
      return $urandom;
   endfunction

   initial begin
      logic [31:0] edge_x [$];
      board = new();
      cycles = 0;
      idle_pct = 7;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: zeros, cutoff neighbors, infinities, NaNs, subnormals, extremes
      edge_x = '{32'h0000_0000, 32'h8000_0000, {1'b1, fem1_pkg::CUTOFF_MAG},
                 {1'b1, fem1_pkg::CUTOFF_MAG + 31'd1},
                 {1'b1, fem1_pkg::CUTOFF_MAG - 31'd1},
                 32'hFF80_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'hFFC0_0001,
                 32'h7F80_0001, 32'h8000_0001, 32'h807F_FFFF, 32'h0000_0001,
                 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h3F80_0000,
                 32'hC188_0000, 32'hBF31_7218, 32'hB380_0000, 32'h42B0_0000,
                 32'hC2B0_0000, 32'hFFFF_FFFF, 32'h0080_0000};
      foreach (edge_x[i]) send(edge_x[i], 1'(i & 1));

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 7 : (phase == 1) ? 74 : 0;
         repeat (400) send(random_x(), 1'($urandom));
      end
      start = 1'b0;

      // Drain, then let the pipeline settle
      while (board.pending.size() != 0) @(posedge clock);
      repeat (fem1_pkg::TOTAL_LAT + 10) @(posedge clock);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
